>>> sv/qsip_pkg.sv
package qsip_pkg;

	localparam int unsigned VALUE_W = 32;

	// sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_POP,
		ST_POP_W,
		ST_PIV,
		ST_R_ADDR,
		ST_R_DATA,
		ST_L_ADDR,
		ST_L_DATA,
		ST_PLACE,
		ST_PUSH_L,
		ST_OUT_ADDR,
		ST_OUT_DATA,
		ST_OUT_WAIT
	} state_t;

endpackage

>>> sv/quicksort_in_place_unit.sv
// In-place quicksort unit. Signed 32-bit values stream in on the slave side, one
// per transaction, one per cycle, into an element store of MAX_ELEMENTS entries;
// values beyond that are dropped and the set is flagged. The transaction with
// tlast high (its value is stored too, if room is left) closes the set and starts
// the sort: each partition takes the first element of its range as pivot and
// fills holes alternately from the right and the left, with pending subranges on
// an explicit stack (left part first). The sorted set then leaves on the master
// side in ascending order, tlast on its final value, tuser high on every value of
// a set that overflowed. The slave side is not ready from the closing transaction
// until the final result has been taken. Each compare step is a registered read of
// the single-read element store, then the shared signed comparator; each result is
// read from the store, registered and held on the master side until it is taken.
module quicksort_in_place_unit
	import qsip_pkg::*;
#(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
	input  logic                s_tlast,   // last
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W-1:0]  m_tdata,   // [31:0] sorted_value
	output logic                m_tlast,   // last_res
	output logic                m_tuser    // [0] overflowed
);

	localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
	localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned RNG_W = 2 * IDX_W;

	state_t state_q, state_nxt;

	// control state
	logic [CNT_W-1:0] count_q;    // elements held in the current set
	logic             ovf_q;      // set dropped elements
	logic [CNT_W-1:0] top_q;      // range stack depth
	logic [IDX_W-1:0] k_q;        // output index
	logic             m_tvalid_q;

	// partition working registers
	logic [IDX_W-1:0]   s_q, e_q, l_q, r_q;
	logic [VALUE_W-1:0] pivot_q;
	logic [VALUE_W-1:0] m_tdata_q;
	logic               m_tlast_q, m_tuser_q;

	// element store port
	logic               st_we;
	logic [IDX_W-1:0]   st_waddr, st_raddr;
	logic [VALUE_W-1:0] st_wdata, st_rdata;

	// range stack port: start in upper half, end in lower half
	logic             sk_we;
	logic [IDX_W-1:0] sk_waddr, sk_raddr;
	logic [RNG_W-1:0] sk_wdata, sk_rdata;

	logic s_acc;
	logic room;
	logic l_lt_r;
	logic push_r, push_l;
	logic out_last;
	logic [CNT_W-1:0] top_dec;

	// shared signed comparator: right scan asks store[r] < pivot,
	// left scan asks pivot < store[l]; either true means a hole gets filled
	logic signed [VALUE_W-1:0] cmp_a, cmp_b;
	logic                      cmp_lt;

	qsip_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	qsip_ram #(.WIDTH(RNG_W), .DEPTH(MAX_ELEMENTS)) u_stack (
		.clk  (clk),
		.we   (sk_we),
		.waddr(sk_waddr),
		.wdata(sk_wdata),
		.raddr(sk_raddr),
		.rdata(sk_rdata)
	);

	assign s_acc    = s_tvalid && s_tready;
	assign room     = count_q < CNT_W'(MAX_ELEMENTS);
	assign l_lt_r   = l_q < r_q;
	assign push_r   = ({1'b0, l_q} + (IDX_W+1)'(1)) < {1'b0, e_q};
	assign push_l   = ({1'b0, s_q} + (IDX_W+1)'(1)) < {1'b0, l_q};
	assign out_last = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
	assign top_dec  = top_q - CNT_W'(1);

	assign cmp_a  = (state_q == ST_L_DATA) ? $signed(pivot_q) : $signed(st_rdata);
	assign cmp_b  = (state_q == ST_L_DATA) ? $signed(st_rdata) : $signed(pivot_q);
	assign cmp_lt = cmp_a < cmp_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		st_we     = 1'b0;
		st_waddr  = l_q;
		st_wdata  = st_rdata;
		st_raddr  = r_q;
		sk_we     = 1'b0;
		sk_waddr  = top_q[IDX_W-1:0];
		sk_wdata  = {s_q, l_q - IDX_W'(1)};
		sk_raddr  = top_dec[IDX_W-1:0];
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				st_waddr = count_q[IDX_W-1:0];
				st_wdata = s_tdata;
				if (s_acc) begin
					st_we = room;
					if (s_tlast) begin
						state_nxt = ST_START;
					end
				end
			end
			ST_START: begin
				if (count_q < CNT_W'(2)) begin
					state_nxt = ST_OUT_ADDR;
				end else begin
					sk_we     = 1'b1;
					sk_waddr  = '0;
					sk_wdata  = {IDX_W'(0), count_q[IDX_W-1:0] - IDX_W'(1)};
					state_nxt = ST_POP;
				end
			end
			ST_POP: begin
				state_nxt = (top_q == '0) ? ST_OUT_ADDR : ST_POP_W;
			end
			ST_POP_W: begin
				st_raddr  = sk_rdata[RNG_W-1:IDX_W];
				state_nxt = ST_PIV;
			end
			ST_PIV: begin
				state_nxt = ST_R_ADDR;
			end
			ST_R_ADDR: begin
				st_raddr  = r_q;
				state_nxt = l_lt_r ? ST_R_DATA : ST_PLACE;
			end
			ST_R_DATA: begin
				if (cmp_lt) begin
					st_we     = 1'b1;
					st_waddr  = l_q;
					state_nxt = ST_L_ADDR;
				end else begin
					state_nxt = ST_R_ADDR;
				end
			end
			ST_L_ADDR: begin
				st_raddr  = l_q;
				state_nxt = l_lt_r ? ST_L_DATA : ST_PLACE;
			end
			ST_L_DATA: begin
				if (cmp_lt) begin
					st_we     = 1'b1;
					st_waddr  = r_q;
					state_nxt = ST_R_ADDR;
				end else begin
					state_nxt = ST_L_ADDR;
				end
			end
			ST_PLACE: begin
				st_we     = 1'b1;
				st_waddr  = l_q;
				st_wdata  = pivot_q;
				sk_we     = push_r;
				sk_wdata  = {l_q + IDX_W'(1), e_q};
				state_nxt = ST_PUSH_L;
			end
			ST_PUSH_L: begin
				sk_we     = push_l;
				state_nxt = ST_POP;
			end
			ST_OUT_ADDR: begin
				st_raddr  = k_q;
				state_nxt = ST_OUT_DATA;
			end
			ST_OUT_DATA: begin
				state_nxt = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (m_tready) begin
					state_nxt = m_tlast_q ? ST_LOAD : ST_OUT_ADDR;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			top_q      <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_START: begin
					top_q <= CNT_W'(1);
					k_q   <= '0;
				end
				ST_POP: begin
					if (top_q != '0) begin
						top_q <= top_dec;
					end
				end
				ST_PLACE: begin
					if (push_r) begin
						top_q <= top_q + CNT_W'(1);
					end
				end
				ST_PUSH_L: begin
					if (push_l) begin
						top_q <= top_q + CNT_W'(1);
					end
				end
				ST_OUT_DATA: begin
					m_tvalid_q <= 1'b1;
				end
				ST_OUT_WAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							k_q     <= '0;
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// partition and output payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_POP_W: begin
				s_q <= sk_rdata[RNG_W-1:IDX_W];
				l_q <= sk_rdata[RNG_W-1:IDX_W];
				e_q <= sk_rdata[IDX_W-1:0];
				r_q <= sk_rdata[IDX_W-1:0];
			end
			ST_PIV: begin
				pivot_q <= st_rdata;
			end
			ST_R_DATA: begin
				if (cmp_lt) begin
					l_q <= l_q + IDX_W'(1);
				end else begin
					r_q <= r_q - IDX_W'(1);
				end
			end
			ST_L_DATA: begin
				if (cmp_lt) begin
					r_q <= r_q - IDX_W'(1);
				end else begin
					l_q <= l_q + IDX_W'(1);
				end
			end
			ST_OUT_DATA: begin
				m_tdata_q <= st_rdata;
				m_tlast_q <= out_last;
				m_tuser_q <= ovf_q;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> sv/qsip_ram.sv
module qsip_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sim/tb_quicksort_in_place_unit.sv
module tb_quicksort_in_place_unit;
	import qsip_pkg::*;

	localparam int unsigned CAPACITY    = 64;
	localparam int unsigned TARGET_VALS = 500;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned DRAIN       = 64;
	localparam int unsigned STALL_LIMIT = 40000;

	// idling modes, one per phase of the random part
	localparam logic [1:0] MODE_FREE   = 2'd0;
	localparam logic [1:0] MODE_GAPS   = 2'd1;
	localparam logic [1:0] MODE_STALLS = 2'd2;
	localparam logic [1:0] MODE_BOTH   = 2'd3;

	// value patterns for a generated set
	localparam int PAT_WIDE    = 0;
	localparam int PAT_NARROW  = 1;
	localparam int PAT_ASCEND  = 2;
	localparam int PAT_DESCEND = 3;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic [1:0]         mode;
		logic               hold;
	} feed_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               ovf;
	} sorted_item_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata  = '0;
	logic               s_tlast  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [VALUE_W-1:0] m_tdata;
	logic               m_tlast;
	logic               m_tuser;

	feed_item_t   feed_q[$];
	sorted_item_t sorted_q[$];

	// predictor copy of the set being collected
	logic signed [VALUE_W-1:0] set_vals[CAPACITY];
	int unsigned               set_count = 0;
	bit                        set_ovf   = 1'b0;

	bit          took_item  = 1'b0;
	logic [1:0]  idle_mode  = MODE_FREE;
	int unsigned hold_req   = 0;
	int unsigned hold_ack   = 0;
	int unsigned hold_left  = 0;
	int unsigned errors     = 0;
	int unsigned sets_done  = 0;
	int unsigned ovf_sets   = 0;
	int unsigned vals_in    = 0;
	int unsigned results_ok = 0;
	int unsigned quiet_cyc  = 0;
	int unsigned queued     = 0;

	quicksort_in_place_unit #(
		.MAX_ELEMENTS(CAPACITY)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sender: offers the head of feed_q, moves on once the transaction went through.
	always @(negedge clk) begin : sender
		bit gap;
		gap = 1'b0;
		if (feed_q.size() != 0) begin
			case (feed_q[0].mode)
				MODE_GAPS: gap = ($urandom_range(99) < 88);
				MODE_BOTH: gap = ($urandom_range(99) < 28);
				default:   gap = 1'b0;
			endcase
		end
		if (arst_n && (!s_tvalid || took_item)) begin
			if (feed_q.size() != 0 && !gap) begin
				s_tvalid  <= 1'b1;
				s_tdata   <= feed_q[0].value;
				s_tlast   <= feed_q[0].last;
				idle_mode <= feed_q[0].mode;
				if (feed_q[0].hold) begin
					feed_q[0].hold = 1'b0;
					hold_req <= hold_req + 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls per phase, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			case (idle_mode)
				MODE_STALLS: m_tready <= arst_n && ($urandom_range(99) >= 88);
				MODE_BOTH:   m_tready <= arst_n && ($urandom_range(99) >= 28);
				default:     m_tready <= arst_n;
			endcase
		end
	end

	// Input side: every accepted value goes into the predictor. A closing value
	// sorts the collected set (ascending, signed) and queues one result per element.
	always @(posedge clk) begin : collect
		logic signed [VALUE_W-1:0] v;
		sorted_item_t              res;
		int                        j;
		took_item <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			void'(feed_q.pop_front());
			vals_in++;
			if (set_count < CAPACITY) begin
				set_vals[set_count] = s_tdata;
				set_count++;
			end else begin
				set_ovf = 1'b1;  // store full, value dropped
			end
			if (s_tlast) begin
				for (int i = 1; i < set_count; i++) begin
					v = set_vals[i];
					j = i;
					while (j > 0 && set_vals[j-1] > v) begin
						set_vals[j] = set_vals[j-1];
						j--;
					end
					set_vals[j] = v;
				end
				for (int k = 0; k < set_count; k++) begin
					res.value = set_vals[k];
					res.last  = (k + 1 == set_count);
					res.ovf   = set_ovf;
					sorted_q.push_back(res);
				end
				sets_done++;
				if (set_ovf)
					ovf_sets++;
				set_count = 0;
				set_ovf   = 1'b0;
			end
		end
	end

	// Output side: each result against the oldest expectation.
	always @(posedge clk) begin : check
		sorted_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_q.size() == 0) begin
				$error("result with nothing expected: sorted_value %0d last_res %0b",
					$signed(m_tdata), m_tlast);
				errors++;
			end else begin
				want = sorted_q.pop_front();
				if (m_tdata !== want.value) begin
					$error("sorted_value: expected %0d, got %0d",
						$signed(want.value), $signed(m_tdata));
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_res: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
				if (m_tuser !== want.ovf) begin
					$error("overflowed: expected %0b, got %0b", want.ovf, m_tuser);
					errors++;
				end
				results_ok++;
			end
		end
	end

	// Watchdog: too long without any transaction on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cyc <= 0;
		else
			quiet_cyc <= quiet_cyc + 1;
		if (quiet_cyc >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic put_value(input logic [VALUE_W-1:0] value, input logic last,
		input logic [1:0] mode, input logic hold);
		feed_item_t it;
		it.value = value;
		it.last  = last;
		it.mode  = mode;
		it.hold  = hold;
		feed_q.push_back(it);
		queued++;
	endtask

	// one set of n values; the final one carries last
	task automatic put_set(input int n, input int pat, input logic [1:0] mode,
		input logic hold);
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] step;
		logic [VALUE_W-1:0] v;
		base = $urandom;
		step = $urandom_range(1, 1000);
		for (int i = 0; i < n; i++) begin
			case (pat)
				PAT_NARROW:  v = $urandom_range(8) - 4;
				PAT_ASCEND:  v = base + i * step;
				PAT_DESCEND: v = base - i * step;
				default:     v = $urandom;
			endcase
			put_value(v, i == n - 1, mode, hold && i == 0);
		end
	endtask

	initial begin : stimulus
		int          r;
		int          n;
		int          pat;
		logic [1:0]  mode;

		// directed: single extremes, mixed extremes, duplicates, ordered runs
		put_value(32'h8000_0000, 1'b1, MODE_FREE, 1'b0);
		put_value(32'h7fff_ffff, 1'b1, MODE_FREE, 1'b0);
		put_value(32'h0000_0000, 1'b0, MODE_FREE, 1'b0);
		put_value(32'hffff_ffff, 1'b0, MODE_FREE, 1'b0);
		put_value(32'h0000_0001, 1'b0, MODE_FREE, 1'b0);
		put_value(32'h7fff_ffff, 1'b0, MODE_FREE, 1'b0);
		put_value(32'h8000_0000, 1'b0, MODE_FREE, 1'b0);
		put_value(32'h5555_5555, 1'b0, MODE_FREE, 1'b0);
		put_value(32'haaaa_aaaa, 1'b1, MODE_FREE, 1'b0);
		for (int i = 0; i < 3; i++)
			put_value(32'd7, i == 2, MODE_FREE, 1'b0);
		for (int i = 0; i < 5; i++)
			put_value(i - 2, i == 4, MODE_FREE, 1'b0);
		for (int i = 0; i < 5; i++)
			put_value(2 - i, i == 4, MODE_FREE, 1'b0);

		// receiver holds off while this set and the next are offered
		put_set(12, PAT_WIDE, MODE_FREE, 1'b1);
		put_set(10, PAT_NARROW, MODE_FREE, 1'b0);
		// worst-case ordering on a full store, then a store overflow with a dropped last
		put_set(CAPACITY, PAT_ASCEND, MODE_FREE, 1'b0);
		put_set(CAPACITY + 6, PAT_WIDE, MODE_GAPS, 1'b0);

		// random sets, mostly small; phases step through the idling modes
		while (queued < TARGET_VALS) begin
			mode = 2'((queued * 4) / TARGET_VALS);
			r = $urandom_range(99);
			if (r < 70)
				n = $urandom_range(1, 12);
			else if (r < 82)
				n = $urandom_range(13, 40);
			else if (r < 90)
				n = CAPACITY;
			else
				n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
			r = $urandom_range(99);
			pat = (r < 45) ? PAT_WIDE : (r < 85) ? PAT_NARROW :
				(r < 93) ? PAT_ASCEND : PAT_DESCEND;
			put_set(n, pat, mode, 1'b0);
		end

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		while (feed_q.size() != 0 || sorted_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("Sorted %0d sets from %0d values (%0d sets overflowed the store).",
			sets_done, vals_in, ovf_sets);
		$display("Checked %0d sorted results across all idling phases and one long hold-off.",
			results_ok);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
